@@ design/tps_pkg.sv @@
// Shared types, constants and register codes for the tile path to screen block.
`default_nettype none
package tps_pkg;

  localparam int TILE_BITS_DEF   = 10;
  localparam int SCREEN_BITS_DEF = 18;

  localparam int ORIGIN_BITS = 16;
  localparam int DRAW_BITS   = 16;
  localparam int MAP_BITS    = 11;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [DRAW_BITS-1:0] DRAW_RESET = 16'd1024;
  localparam logic [MAP_BITS-1:0]  MAP_RESET  = 11'd1;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT  = 3'd5;

  // per-axis settings handed to a mapping unit
  typedef struct packed {
    logic signed [ORIGIN_BITS-1:0] origin;
    logic [DRAW_BITS-1:0]          draw;
    logic [MAP_BITS-1:0]           size;
  } axis_cfg_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_MUL,
    MS_DIV,
    MS_FIN
  } map_state_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_MAP,
    TS_PUSH
  } top_state_t;

endpackage
`default_nettype wire

@@ design/tps_map_unit.sv @@
// Bit-serial tile to screen mapping: shift-add multiply, restoring divide, offset and clamp.
`default_nettype none
module tps_map_unit #(
  parameter int TILE_BITS   = tps_pkg::TILE_BITS_DEF,
  parameter int SCREEN_BITS = tps_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [TILE_BITS-1:0]          tile,
  input  wire tps_pkg::axis_cfg_t            cfg,
  output logic                               done,
  output logic signed [SCREEN_BITS-1:0]      result
);
  import tps_pkg::*;

  localparam int MB = TILE_BITS + 1;          // bits of 2t+1
  localparam int PW = MB + DRAW_BITS;         // product / dividend width
  localparam int RW = MAP_BITS + 2;           // remainder width, divisor is up to 2*2047
  localparam int CW = $clog2(PW + 1);
  localparam int EW = ((PW > SCREEN_BITS) ? PW : SCREEN_BITS) + 2;
  localparam logic signed [EW-1:0] SAT_HI = EW'((longint'(1) << (SCREEN_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  map_state_t state, state_next;

  logic [CW-1:0] cnt;
  logic [MB-1:0] mplier;
  logic [PW-1:0] acc;
  logic [RW-1:0] rem;

  logic [MAP_BITS-1:0] size_eff;
  logic [RW-1:0]       divisor;
  logic [RW-1:0]       trial;
  logic                qbit;
  logic signed [EW-1:0] sum;

  assign size_eff = (cfg.size == '0) ? MAP_BITS'(1) : cfg.size;
  assign divisor  = {1'b0, size_eff, 1'b0};
  assign trial    = {rem[RW-2:0], acc[PW-1]};
  assign qbit     = (trial >= divisor);
  assign sum      = EW'(cfg.origin) + $signed({{(EW-PW){1'b0}}, acc});

  always_comb begin
    state_next = state;
    case (state)
      MS_IDLE: if (start) state_next = MS_MUL;
      MS_MUL:  if (cnt == CW'(MB - 1)) state_next = MS_DIV;
      MS_DIV:  if (cnt == CW'(PW - 1)) state_next = MS_FIN;
      MS_FIN:  state_next = MS_IDLE;
      default: state_next = MS_IDLE;
    endcase
  end

  always_comb begin
    done = (state == MS_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MS_IDLE: begin
        mplier <= {tile, 1'b1};
        acc    <= '0;
        cnt    <= '0;
      end
      MS_MUL: begin
        // MSB first: acc = 2*acc + bit*draw
        acc    <= {acc[PW-2:0], 1'b0} + (mplier[MB-1] ? PW'(cfg.draw) : '0);
        mplier <= {mplier[MB-2:0], 1'b0};
        cnt    <= (cnt == CW'(MB - 1)) ? '0 : cnt + CW'(1);
        rem    <= '0;
      end
      MS_DIV: begin
        rem <= qbit ? (trial - divisor) : trial;
        acc <= {acc[PW-2:0], qbit};
        cnt <= cnt + CW'(1);
      end
      MS_FIN: begin
        if (sum > SAT_HI) begin
          result <= SAT_HI[SCREEN_BITS-1:0];
        end else if (sum < SAT_LO) begin
          result <= SAT_LO[SCREEN_BITS-1:0];
        end else begin
          result <= sum[SCREEN_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/tile_path_to_smoothed_screen.sv @@
// In state TS_IDLE a point is taken; both mapping units then run a bit-serial multiply
// (TILE_BITS+1 steps) and restoring divide (TILE_BITS+17 steps), and a new point is
// taken only after the result of the last one has been pushed into the output queue.
// Results queue in a two-entry output buffer, so the next point maps while they drain.
// Reset (rst, synchronous): registers return to their defaults, path state and queue clear.
`default_nettype none
module tile_path_to_smoothed_screen #(
  parameter int TILE_BITS   = tps_pkg::TILE_BITS_DEF,
  parameter int SCREEN_BITS = tps_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [tps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [tps_pkg::CFG_BITS-1:0]          cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [TILE_BITS-1:0]                  tile_x,
  input  wire logic [TILE_BITS-1:0]                  tile_y,
  input  wire logic                                  last_point,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [SCREEN_BITS-1:0]              screen_x,
  output logic signed [SCREEN_BITS-1:0]              screen_y,
  output logic                                       end_of_path
);
  import tps_pkg::*;

  localparam int SW = SCREEN_BITS + 2;

  axis_cfg_t cfg_x, cfg_y;

  top_state_t state, state_next;
  logic start, done_x, done_y, last_reg;
  logic signed [SCREEN_BITS-1:0] sx, sy;

  logic signed [SCREEN_BITS-1:0] older_x, older_y, newer_x, newer_y;
  logic [1:0] points_seen;

  logic signed [SCREEN_BITS-1:0] head_x, head_y, tail_x, tail_y;
  logic head_end, tail_end;
  logic [1:0] out_count;

  logic signed [SW-1:0] sum_x, sum_y, adj_x, adj_y;
  logic signed [SCREEN_BITS-1:0] mid_x, mid_y, first_x, first_y;
  logic push;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_x.origin <= '0;
      cfg_y.origin <= '0;
      cfg_x.draw   <= DRAW_RESET;
      cfg_y.draw   <= DRAW_RESET;
      cfg_x.size   <= MAP_RESET;
      cfg_y.size   <= MAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X:    cfg_x.origin <= cfg_data[ORIGIN_BITS-1:0];
        REG_ORIGIN_Y:    cfg_y.origin <= cfg_data[ORIGIN_BITS-1:0];
        REG_DRAW_WIDTH:  cfg_x.draw   <= cfg_data[DRAW_BITS-1:0];
        REG_DRAW_HEIGHT: cfg_y.draw   <= cfg_data[DRAW_BITS-1:0];
        REG_MAP_WIDTH:   cfg_x.size   <= cfg_data[MAP_BITS-1:0];
        REG_MAP_HEIGHT:  cfg_y.size   <= cfg_data[MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  tps_map_unit #(
    .TILE_BITS   (TILE_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_map_x (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .tile   (tile_x),
    .cfg    (cfg_x),
    .done   (done_x),
    .result (sx)
  );

  tps_map_unit #(
    .TILE_BITS   (TILE_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_map_y (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .tile   (tile_y),
    .cfg    (cfg_y),
    .done   (done_y),
    .result (sy)
  );

  always_comb begin
    state_next = state;
    case (state)
      TS_IDLE: if (in_valid) state_next = TS_MAP;
      TS_MAP:  if (done_x) state_next = TS_PUSH;
      TS_PUSH: if (out_count == 2'd0) state_next = TS_IDLE;
      default: state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == TS_IDLE);
    start    = in_valid && (state == TS_IDLE);
    push     = (state == TS_PUSH) && (out_count == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) last_reg <= last_point;
  end

  // 1-2-1 smoothing, divide by 4 rounding toward zero
  always_comb begin
    sum_x = SW'(older_x) + (SW'(newer_x) <<< 1) + SW'(sx);
    sum_y = SW'(older_y) + (SW'(newer_y) <<< 1) + SW'(sy);
    adj_x = sum_x[SW-1] ? sum_x + SW'(3) : sum_x;
    adj_y = sum_y[SW-1] ? sum_y + SW'(3) : sum_y;
    mid_x = adj_x[SW-1:2];
    mid_y = adj_y[SW-1:2];
    first_x = (points_seen == 2'd1) ? newer_x : mid_x;
    first_y = (points_seen == 2'd1) ? newer_y : mid_y;
  end

  // path delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      older_x <= '0;
      older_y <= '0;
      newer_x <= '0;
      newer_y <= '0;
    end else if (push) begin
      if (last_reg) begin
        points_seen <= 2'd0;
        older_x <= '0;
        older_y <= '0;
        newer_x <= '0;
        newer_y <= '0;
      end else begin
        points_seen <= (points_seen == 2'd0) ? 2'd1 : 2'd2;
        older_x <= newer_x;
        older_y <= newer_y;
        newer_x <= sx;
        newer_y <= sy;
      end
    end
  end

  // two-entry output queue, head is presented
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else if (push) begin
      if (points_seen == 2'd0) begin
        out_count <= 2'd0;
      end else begin
        out_count <= last_reg ? 2'd2 : 2'd1;
      end
    end else if (out_valid && out_ready) begin
      out_count <= out_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (points_seen == 2'd0) begin
        head_x   <= sx;
        head_y   <= sy;
        head_end <= 1'b0;
      end else begin
        head_x   <= first_x;
        head_y   <= first_y;
        head_end <= 1'b0;
      end
      tail_x   <= sx;
      tail_y   <= sy;
      tail_end <= 1'b1;
    end else if (out_valid && out_ready) begin
      head_x   <= tail_x;
      head_y   <= tail_y;
      head_end <= tail_end;
    end
  end

  assign out_valid   = (out_count != 2'd0);
  assign screen_x    = head_x;
  assign screen_y    = head_y;
  assign end_of_path = head_end;

  a_units_lockstep: assert property (@(posedge clk) disable iff (rst)
    done_x == done_y)
    else $error("mapping units out of step");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3 && points_seen != 2'd3)
    else $error("queue count or path count out of range");

  a_no_load_over_queue: assert property (@(posedge clk) disable iff (rst)
    (state == TS_PUSH && out_count != 2'd0) |=> state == TS_PUSH)
    else $error("left push state while queue still occupied");

  a_end_flag_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_path) |-> out_count == 2'd1)
    else $error("end of path flagged ahead of another result");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for tile_path_to_smoothed_screen: directed table, then random paths.
`timescale 1ns / 1ps
module tb_top;
  import tps_pkg::*;

  localparam int TW = TILE_BITS_DEF;
  localparam int SW = SCREEN_BITS_DEF;
  localparam int RAND_ITEMS = 1700;
  // time allowed for the mapping units to go quiet after the last result; keep some slack
  localparam int SETTLE = 2 * TW + 40;
  localparam int STALL_LIMIT = 2000;
  localparam longint SCR_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SCR_MIN = -SCR_MAX - 1;
  localparam logic signed [SW-1:0] SAT_HI = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [CFG_IDX_BITS-1:0] IDX_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] IDX_UNUSED_B = 3'd7;

  typedef struct packed {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic                 eop;
  } screen_pt_t;

  typedef struct packed {
    logic                    is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_BITS-1:0]     data;
    logic [TW-1:0]           tx;
    logic [TW-1:0]           ty;
    logic                    lp;
    logic                    fixed;
    logic [1:0]              n_fixed;
    screen_pt_t              r0;
    screen_pt_t              r1;
  } stim_row_t;

  localparam screen_pt_t NO_PT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TW-1:0] tile_x = '0;
  logic [TW-1:0] tile_y = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] screen_x;
  logic signed [SW-1:0] screen_y;
  logic end_of_path;

  // predictor copy of the registers and the two-point delay line
  logic signed [ORIGIN_BITS-1:0] org_x = '0;
  logic signed [ORIGIN_BITS-1:0] org_y = '0;
  logic [DRAW_BITS-1:0] draw_w = DRAW_RESET;
  logic [DRAW_BITS-1:0] draw_h = DRAW_RESET;
  logic [MAP_BITS-1:0] map_w = MAP_RESET;
  logic [MAP_BITS-1:0] map_h = MAP_RESET;
  logic signed [SW-1:0] prev_x = '0;
  logic signed [SW-1:0] prev_y = '0;
  logic signed [SW-1:0] cur_x = '0;
  logic signed [SW-1:0] cur_y = '0;
  int held = 0;

  screen_pt_t pts_due[$];
  stim_row_t stim_rows[$];
  int mismatches = 0;
  bit no_stall = 1'b0;

  tile_path_to_smoothed_screen u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tile_x(tile_x),
    .tile_y(tile_y),
    .last_point(last_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .screen_x(screen_x),
    .screen_y(screen_y),
    .end_of_path(end_of_path)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic screen_pt_t mk_pt(input logic signed [SW-1:0] x,
                                       input logic signed [SW-1:0] y, input logic e);
    screen_pt_t p;
    p.sx = x;
    p.sy = y;
    p.eop = e;
    return p;
  endfunction

  // tile center on screen, clamped to the signed output range
  function automatic logic signed [SW-1:0] map_axis(input logic signed [ORIGIN_BITS-1:0] org,
      input logic [TW-1:0] t, input logic [DRAW_BITS-1:0] span_px,
      input logic [MAP_BITS-1:0] tiles);
    longint denom;
    longint v;
    denom = (tiles == '0) ? 64'sd2 : 2 * longint'(tiles);
    v = longint'(org) + ((2 * longint'(t) + 1) * longint'(span_px)) / denom;
    if (v > SCR_MAX) v = SCR_MAX;
    if (v < SCR_MIN) v = SCR_MIN;
    return v[SW-1:0];
  endfunction

  // 1-2-1 filter, division truncates toward zero
  function automatic logic signed [SW-1:0] smooth3(input logic signed [SW-1:0] a,
      input logic signed [SW-1:0] b, input logic signed [SW-1:0] c);
    longint s;
    s = (longint'(a) + 2 * longint'(b) + longint'(c)) / 4;
    return s[SW-1:0];
  endfunction

  function automatic int path_step(input logic [TW-1:0] tx, input logic [TW-1:0] ty,
                                   input logic lp, output screen_pt_t p0, output screen_pt_t p1);
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    int n;
    p0 = NO_PT;
    p1 = NO_PT;
    sx = map_axis(org_x, tx, draw_w, map_w);
    sy = map_axis(org_y, ty, draw_h, map_h);
    if (held == 0) begin
      // a path of one point is dropped
      if (!lp) begin
        cur_x = sx;
        cur_y = sy;
        held = 1;
      end
      return 0;
    end
    if (held == 1) p0 = mk_pt(cur_x, cur_y, 1'b0);
    else p0 = mk_pt(smooth3(prev_x, cur_x, sx), smooth3(prev_y, cur_y, sy), 1'b0);
    n = 1;
    if (lp) begin
      p1 = mk_pt(sx, sy, 1'b1);
      n = 2;
      prev_x = '0;
      prev_y = '0;
      cur_x = '0;
      cur_y = '0;
      held = 0;
    end else begin
      prev_x = cur_x;
      prev_y = cur_y;
      cur_x = sx;
      cur_y = sy;
      held = 2;
    end
    return n;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_BITS-1:0] val);
    case (idx)
      REG_ORIGIN_X:    org_x = val;
      REG_ORIGIN_Y:    org_y = val;
      REG_DRAW_WIDTH:  draw_w = val;
      REG_DRAW_HEIGHT: draw_h = val;
      REG_MAP_WIDTH:   map_w = val[MAP_BITS-1:0];
      REG_MAP_HEIGHT:  map_h = val[MAP_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t row_pt(input logic [TW-1:0] tx, input logic [TW-1:0] ty,
                                       input logic lp);
    stim_row_t r;
    r = '0;
    r.tx = tx;
    r.ty = ty;
    r.lp = lp;
    return r;
  endfunction

  function automatic stim_row_t row_exp(input logic [TW-1:0] tx, input logic [TW-1:0] ty,
      input logic lp, input logic [1:0] n, input screen_pt_t p0, input screen_pt_t p1);
    stim_row_t r;
    r = row_pt(tx, ty, lp);
    r.fixed = 1'b1;
    r.n_fixed = n;
    r.r0 = p0;
    r.r1 = p1;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_BITS-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_setting(input logic [CFG_IDX_BITS-1:0] idx);
    logic [31:0] w;
    int c;
    int v;
    w = $urandom;
    c = $urandom_range(0, 5);
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y: begin
        if (c == 0) return 16'h8000;
        if (c == 1) return 16'h7fff;
        if (c == 2) return '0;
        return w[CFG_BITS-1:0];
      end
      REG_DRAW_WIDTH, REG_DRAW_HEIGHT: begin
        if (c == 0) return '0;
        if (c == 1) return '1;
        if (c == 2) return w[CFG_BITS-1:0];
        v = $urandom_range(1, 4096);
        return v[CFG_BITS-1:0];
      end
      REG_MAP_WIDTH, REG_MAP_HEIGHT: begin
        if (c == 0) return '0;
        if (c == 1) return 16'd1;
        if (c == 2) return 16'd1024;
        if (c == 3) return w[CFG_BITS-1:0];  // upper bits must be dropped
        v = $urandom_range(1, 1024);
        return v[CFG_BITS-1:0];
      end
      default: return w[CFG_BITS-1:0];
    endcase
  endfunction

  // mostly tiles inside the map, so results are not all clamped
  function automatic logic [TW-1:0] pick_tile(input logic [MAP_BITS-1:0] tiles);
    logic [31:0] w;
    int c;
    int v;
    w = $urandom;
    c = $urandom_range(0, 9);
    if (c == 0) return '0;
    if (c == 1) return '1;
    if (c < 5 || tiles < 2) return w[TW-1:0];
    v = (tiles > 11'd1024) ? 1023 : int'(tiles) - 1;
    v = $urandom_range(0, v);
    return v[TW-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // no results owed and the mapping units quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic feed_row(input stim_row_t row);
    screen_pt_t p0;
    screen_pt_t p1;
    int n;
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tile_x <= row.tx;
    tile_y <= row.ty;
    last_point <= row.lp;
    do @(posedge clk); while (!in_ready);
    n = path_step(row.tx, row.ty, row.lp, p0, p1);
    if (row.fixed) begin
      n = row.n_fixed;
      p0 = row.r0;
      p1 = row.r1;
    end
    if (n > 0) pts_due.push_back(p0);
    if (n > 1) pts_due.push_back(p1);
  endtask

  task automatic random_settings();
    logic [CFG_IDX_BITS-1:0] ri;
    bit wrote;
    wrote = 1'b0;
    wait_idle();
    for (int r = 0; r < 8; r++) begin
      ri = r[CFG_IDX_BITS-1:0];
      if ($urandom_range(0, 1) == 1) begin
        write_reg(ri, pick_setting(ri));
        wrote = 1'b1;
      end
    end
    if (wrote) cfg_write <= 1'b0;
  endtask

  // receiver: random stall per transfer
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_out
    screen_pt_t want;
    if (!rst && out_valid && out_ready) begin
      if (pts_due.size() == 0) begin
        flag_mismatch("point with none owed, screen_x", screen_x, 0);
      end else begin
        want = pts_due.pop_front();
        if (screen_x !== want.sx) flag_mismatch("screen_x", screen_x, want.sx);
        if (screen_y !== want.sy) flag_mismatch("screen_y", screen_y, want.sy);
        if (end_of_path !== want.eop) flag_mismatch("end_of_path", end_of_path, want.eop);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[tile_path_to_smoothed_screen] ERROR");
    $finish;
  end

  initial begin
    bit in_cfg;
    int sent;
    int paths_left;
    int len;

    // reset settings: x = y = (2t+1)*512, clamped
    stim_rows.push_back(row_exp(0, 0, 1'b1, 0, NO_PT, NO_PT));  // one-point path
    stim_rows.push_back(row_exp(0, 0, 1'b0, 0, NO_PT, NO_PT));
    stim_rows.push_back(row_exp('1, '1, 1'b1, 2, mk_pt(18'sd512, 18'sd512, 1'b0),
                                mk_pt(SAT_HI, SAT_HI, 1'b1)));  // two points, clamped end
    stim_rows.push_back(row_exp(0, '1, 1'b0, 0, NO_PT, NO_PT));
    stim_rows.push_back(row_exp('1, 0, 1'b0, 1, mk_pt(18'sd512, SAT_HI, 1'b0), NO_PT));
    stim_rows.push_back(row_pt(0, 0, 1'b1));
    stim_rows.push_back(row_exp(127, 128, 1'b0, 0, NO_PT, NO_PT));
    stim_rows.push_back(row_exp(5, 300, 1'b0, 1, mk_pt(18'sd130560, SAT_HI, 1'b0), NO_PT));
    stim_rows.push_back(row_pt(1, 2, 1'b0));
    stim_rows.push_back(row_pt(3, 3, 1'b1));
    // register extremes; map size zero acts as one
    stim_rows.push_back(row_cfg(REG_ORIGIN_X, 16'h8000));
    stim_rows.push_back(row_cfg(REG_ORIGIN_Y, 16'h7fff));
    stim_rows.push_back(row_cfg(REG_DRAW_WIDTH, 16'hffff));
    stim_rows.push_back(row_cfg(REG_DRAW_HEIGHT, 16'h0000));
    stim_rows.push_back(row_cfg(REG_MAP_WIDTH, 16'h0000));
    stim_rows.push_back(row_cfg(REG_MAP_HEIGHT, 16'd1024));
    stim_rows.push_back(row_exp(0, 0, 1'b0, 0, NO_PT, NO_PT));
    stim_rows.push_back(row_exp(0, '1, 1'b1, 2, mk_pt(-18'sd1, 18'sd32767, 1'b0),
                                mk_pt(-18'sd1, 18'sd32767, 1'b1)));
    // negative screen values, masked map size, writes to unused indexes
    stim_rows.push_back(row_cfg(REG_ORIGIN_Y, 16'hfff0));
    stim_rows.push_back(row_cfg(REG_DRAW_WIDTH, 16'd7));
    stim_rows.push_back(row_cfg(REG_DRAW_HEIGHT, 16'hffff));
    stim_rows.push_back(row_cfg(REG_MAP_WIDTH, 16'hf801));
    stim_rows.push_back(row_cfg(REG_MAP_HEIGHT, 16'd3));
    stim_rows.push_back(row_cfg(IDX_UNUSED_A, 16'hffff));
    stim_rows.push_back(row_cfg(IDX_UNUSED_B, 16'h0000));
    stim_rows.push_back(row_pt(0, 5, 1'b0));
    stim_rows.push_back(row_pt(1, 0, 1'b0));
    stim_rows.push_back(row_pt('1, 2, 1'b0));
    stim_rows.push_back(row_pt(2, '1, 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    in_cfg = 1'b0;
    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        write_reg(stim_rows[k].idx, stim_rows[k].data);
      end else begin
        if (in_cfg) cfg_write <= 1'b0;
        in_cfg = 1'b0;
        feed_row(stim_rows[k]);
      end
    end

    // random paths, settings changed between groups of paths
    sent = 0;
    paths_left = 0;
    while (sent < RAND_ITEMS) begin
      if (paths_left == 0) begin
        random_settings();
        paths_left = $urandom_range(4, 16);
      end
      no_stall = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(13, 40);
      for (int k = 0; k < len; k++) begin
        feed_row(row_pt(pick_tile(map_w), pick_tile(map_h), k == len - 1));
        sent++;
      end
      paths_left--;
    end

    wait_idle();
    if (mismatches == 0) $display("[tile_path_to_smoothed_screen] OK");
    else $display("[tile_path_to_smoothed_screen] ERROR");
    $finish;
  end

endmodule
